// ===== rtl/core/multichannel_iir_df2t_filter_unit_assert.svh =====
// Assertion macros used by the checker file of the IIR filter unit.
// Depends on signals named clk and rst in the module that uses them.
`ifndef MULTICHANNEL_IIR_DF2T_FILTER_UNIT_ASSERT_SVH
`define MULTICHANNEL_IIR_DF2T_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define IIRDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, skipped while in reset
`define IIRDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that also covers the cycles around reset
`define IIRDF_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/iirdf_pkg.sv =====
// Types, codes and helper functions of the multichannel DF2T IIR filter unit.
// No dependencies; used by every module of the block.
package iirdf_pkg;

  localparam int MAX_TAPS   = 8;
  localparam int NUM_SLOTS  = 64;
  localparam int COEF_DEPTH = NUM_SLOTS * MAX_TAPS;
  localparam int HIST_DEPTH = NUM_SLOTS * (MAX_TAPS - 1);

  localparam logic [1:0] FUNC_COEF_WR = 2'd0;
  localparam logic [1:0] FUNC_HIST_WR = 2'd1;
  localparam logic [1:0] FUNC_FILTER  = 2'd2;
  localparam logic [1:0] FUNC_HIST_RD = 2'd3;

  localparam logic RESULT_FILTER = 1'b0;
  localparam logic RESULT_HIST   = 1'b1;

  localparam logic CFG_TAP_COUNT = 1'b0;
  localparam logic CFG_SHARED    = 1'b1;

  localparam logic [2:0] LAST_TAP = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         slot;
    logic [2:0]         tap;
    logic               coef_kind;
    logic signed [47:0] word;
    logic signed [15:0] sample;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] out_sample;
    logic signed [47:0] history_word;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    logic       clr;
    logic [8:0] clr_addr;
    logic       rd;
    logic       hrd;
    logic       mul;
    logic       acc;
    logic       put;
    logic [2:0] k;
  } cmd_t;

  typedef struct packed {
    logic [3:0] taps;
    logic       out_free;
  } stat_t;

  function automatic logic [8:0] hist_addr(input logic [5:0] slot, input logic [2:0] pos);
    logic [8:0] s9;
    logic [2:0] p;
    s9 = {3'b000, slot};
    p  = (pos == LAST_TAP) ? 3'd0 : pos;
    return (s9 << 3) - s9 + {6'b000000, p};
  endfunction

  // {clipped, value}
  function automatic logic [48:0] sat_hist(input logic signed [59:0] v);
    logic [48:0] r;
    if (v[59:47] == {13{v[47]}}) r = {1'b0, v[47:0]};
    else if (v[59]) r = {1'b1, 1'b1, 47'd0};
    else r = {1'b1, 1'b0, {47{1'b1}}};
    return r;
  endfunction

  function automatic logic [16:0] sat_out(input logic signed [25:0] v);
    logic [16:0] r;
    if (v[25:15] == {11{v[15]}}) r = {1'b0, v[15:0]};
    else if (v[25]) r = {1'b1, 1'b1, 15'd0};
    else r = {1'b1, 1'b0, {15{1'b1}}};
    return r;
  endfunction

endpackage

// ===== rtl/core/iirdf_ctrl.sv =====
// Sequencer of the IIR filter unit: history clear after reset, per-tap passes, history reads.
// Depends on iirdf_pkg; drives the datapath through iirdf_pkg::cmd_t.
module iirdf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_func,
  input  iirdf_pkg::stat_t   stat,
  output logic               req_stall,
  output iirdf_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_HREAD = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] k, k_next;
  logic [8:0] clr_cnt, clr_cnt_next;

  always_comb begin
    state_next   = state;
    k_next       = k;
    clr_cnt_next = clr_cnt;
    req_stall    = 1'b1;
    cmd          = '0;
    cmd.k        = k;
    cmd.clr_addr = clr_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr      = 1'b1;
        clr_cnt_next = clr_cnt + 9'd1;
        if (clr_cnt == 9'(iirdf_pkg::HIST_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_stall = 1'b0;
        k_next    = 3'd0;
        if (req_valid) begin
          if (req_func == iirdf_pkg::FUNC_FILTER) state_next = S_READ;
          else if (req_func == iirdf_pkg::FUNC_HIST_RD) state_next = S_HREAD;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        // one pass per tap; the last pass retires the sample
        if ({1'b0, k} + 4'd1 >= stat.taps) state_next = S_PUT;
        else begin
          k_next     = k + 3'd1;
          state_next = S_READ;
        end
      end
      S_HREAD: begin
        cmd.hrd    = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      k       <= 3'd0;
      clr_cnt <= 9'd0;
    end else begin
      state   <= state_next;
      k       <= k_next;
      clr_cnt <= clr_cnt_next;
    end
  end

endmodule

// ===== rtl/core/iirdf_dp.sv =====
// Datapath of the IIR filter unit: coefficient and history memories,
// multipliers, accumulate and saturate, config and output registers. Uses iirdf_pkg.
module iirdf_dp (
  input  logic               clk,
  input  logic               rst,
  input  iirdf_pkg::req_t    req,
  input  logic               accept,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  iirdf_pkg::cmd_t    cmd,
  output iirdf_pkg::stat_t   stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output iirdf_pkg::rsp_t    rsp
);

  logic [3:0] tap_count;
  logic       shared_filter;
  iirdf_pkg::req_t cur;

  logic [31:0] num_mem [iirdf_pkg::COEF_DEPTH];
  logic [31:0] den_mem [iirdf_pkg::COEF_DEPTH];
  logic [47:0] hist_mem [iirdf_pkg::HIST_DEPTH];

  logic signed [31:0] b_q, a_q;
  logic signed [47:0] z_q, zr;
  logic signed [47:0] pbx;
  logic signed [55:0] pah;
  logic signed [56:0] pal;
  logic signed [47:0] yh;
  logic signed [23:0] yh_hi;
  logic signed [24:0] yh_lo;
  logic signed [15:0] osamp;
  logic               sat_acc;

  logic [3:0]  taps;
  logic [5:0]  cset;
  logic [8:0]  caddr, hraddr, hwaddr, haddr_wr;
  logic        more_taps;
  logic signed [49:0] y_rnd;
  logic signed [59:0] y_ext, s_sum;
  logic signed [57:0] rnd_lo;
  logic [16:0] o_sat;
  logic [48:0] yh_sat, z_sat;

  always_comb begin
    if (tap_count == 4'd0) taps = 4'd1;
    else if (tap_count > 4'(iirdf_pkg::MAX_TAPS)) taps = 4'(iirdf_pkg::MAX_TAPS);
    else taps = tap_count;
  end

  assign stat.taps     = taps;
  assign stat.out_free = !rsp_valid || !rsp_stall;

  assign cset      = shared_filter ? 6'd0 : cur.slot;
  assign caddr     = {cset, cmd.k};
  assign hraddr    = cmd.hrd ? iirdf_pkg::hist_addr(cur.slot, cur.tap)
                             : iirdf_pkg::hist_addr(cur.slot, cmd.k);
  assign hwaddr    = iirdf_pkg::hist_addr(cur.slot, cmd.k - 3'd1);
  assign haddr_wr  = iirdf_pkg::hist_addr(req.slot, req.tap);
  assign more_taps = ({1'b0, cmd.k} + 4'd1) < taps;

  assign yh_hi = $signed(yh[47:24]);
  assign yh_lo = $signed({1'b0, yh[23:0]});

  // output and fed-back value from the first pass
  assign y_ext  = 60'(pbx) + 60'(zr);
  assign y_rnd  = 50'(pbx) + 50'(zr) + 50'sd8388608;
  assign o_sat  = iirdf_pkg::sat_out($signed(y_rnd[49:24]));
  assign yh_sat = iirdf_pkg::sat_hist(y_ext);

  // z = b*x + z' + floor((2^23 - a*yh) / 2^24), yh split in high and low halves
  assign rnd_lo = 58'sd8388608 - 58'(pal);
  assign s_sum  = 60'(pbx) + 60'(zr) - 60'(pah) + 60'($signed(rnd_lo[57:24]));
  assign z_sat  = iirdf_pkg::sat_hist(s_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count     <= 4'd1;
      shared_filter <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iirdf_pkg::CFG_TAP_COUNT: tap_count <= cfg_data;
        iirdf_pkg::CFG_SHARED:    shared_filter <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= req;
  end

  always_ff @(posedge clk) begin
    if (accept && req.func == iirdf_pkg::FUNC_COEF_WR) begin
      if (req.coef_kind) den_mem[{req.slot, req.tap}] <= req.word[31:0];
      else num_mem[{req.slot, req.tap}] <= req.word[31:0];
    end
    if (cmd.rd) begin
      b_q <= $signed(num_mem[caddr]);
      a_q <= $signed(den_mem[caddr]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      hist_mem[cmd.clr_addr] <= '0;
    end else if (accept && req.func == iirdf_pkg::FUNC_HIST_WR &&
                 req.tap != iirdf_pkg::LAST_TAP) begin
      hist_mem[haddr_wr] <= req.word;
    end else if (cmd.acc && cmd.k != 3'd0) begin
      hist_mem[hwaddr] <= z_sat[47:0];
    end
    if (cmd.rd || cmd.hrd) z_q <= $signed(hist_mem[hraddr]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pbx <= b_q * cur.sample;
      pah <= a_q * yh_hi;
      pal <= a_q * yh_lo;
      zr  <= more_taps ? z_q : 48'sd0;
    end
    if (cmd.acc) begin
      if (cmd.k == 3'd0) begin
        osamp   <= $signed(o_sat[15:0]);
        yh      <= $signed(yh_sat[47:0]);
        sat_acc <= o_sat[16] | ((taps > 4'd1) & yh_sat[48]);
      end else begin
        sat_acc <= sat_acc | z_sat[48];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.put) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      if (cur.func == iirdf_pkg::FUNC_HIST_RD) begin
        rsp.result_kind  <= iirdf_pkg::RESULT_HIST;
        rsp.out_sample   <= 16'sd0;
        rsp.history_word <= (cur.tap == iirdf_pkg::LAST_TAP) ? 48'sd0 : z_q;
        rsp.saturated    <= 1'b0;
      end else begin
        rsp.result_kind  <= iirdf_pkg::RESULT_FILTER;
        rsp.out_sample   <= osamp;
        rsp.history_word <= 48'sd0;
        rsp.saturated    <= sat_acc;
      end
    end
  end

endmodule

// ===== rtl/core/multichannel_iir_df2t_filter_unit.sv =====
// Multichannel direct form II transposed IIR filter unit: 64 slots, up to 8 taps,
// Q8.24 coefficients and Q24.24 saturating history; 16-bit rounded output.
// Request channel: req_valid / req_stall / req. func selects coefficient write,
// history write, filter sample or history read for the addressed slot and tap.
// Response channel: rsp_valid / rsp_stall / rsp. Filter samples and history
// reads give one beat each; writes give none.
// Config: cfg_we with cfg_index 0 writes tap_count, 1 writes shared_filter.
// Writes are done when they are accepted. A history read passes through the HREAD
// and PUT states; its beat is registered from PUT.
// A filter sample passes through the READ, MUL and ACC states once per tap (n taps in
// use), one pass of the coefficient and history memory read ports and the multipliers
// per tap, then through PUT, which waits while the output register is not free.
// One request is worked at a time; req_stall is high until it is done.
// Reset: tap_count 1, shared filter on, and a pass over all 448 history words zeroes
// the history memory, during which req_stall stays high. Coefficients must be written
// before use.
// A stalled response beat holds in the output register; the next request is
// accepted meanwhile, and a further beat waits until the register frees.
module multichannel_iir_df2t_filter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  iirdf_pkg::req_t    req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output iirdf_pkg::rsp_t    rsp,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  iirdf_pkg::cmd_t  cmd;
  iirdf_pkg::stat_t stat;
  logic             accept;

  assign accept = req_valid && !req_stall;

  iirdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .stat      (stat),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  iirdf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .accept    (accept),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/iirdf_chk.sv =====
// Port-level checker of the IIR filter unit, bound to the top level.
// Depends on iirdf_pkg and multichannel_iir_df2t_filter_unit_assert.svh.
`include "multichannel_iir_df2t_filter_unit_assert.svh"

module iirdf_chk (
  input logic            clk,
  input logic            rst,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input iirdf_pkg::rsp_t rsp
);

  `IIRDF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response beat changed")
  `IIRDF_ASSERT_NOW(a_hist_clean, rsp_valid && rsp.result_kind == iirdf_pkg::RESULT_HIST, !rsp.saturated && rsp.out_sample == 16'sd0, "history read beat carries filter fields")
  `IIRDF_ASSERT_NOW(a_filt_clean, rsp_valid && rsp.result_kind == iirdf_pkg::RESULT_FILTER, rsp.history_word == 48'sd0, "filter beat carries history data")
  `IIRDF_ASSERT_NOW(a_rst_quiet, $past(rst), req_stall && !rsp_valid, "block not quiet after reset")

endmodule

bind multichannel_iir_df2t_filter_unit iirdf_chk u_iirdf_chk (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== verif/tb.sv =====
// Self-checking bench for multichannel_iir_df2t_filter_unit: a clocked driver and
// monitor, a bit-true DF2T predictor, phases over tap count and shared set.
// Depends on iirdf_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE = 40;
  localparam logic signed [127:0] HMAX = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] HMIN = -(128'sd1 <<< 47);
  localparam logic signed [127:0] HALF = 128'sd1 <<< 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  iirdf_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  iirdf_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [3:0] cfg_data = 4'd0;

  multichannel_iir_df2t_filter_unit DUT (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  logic signed [31:0] num_coef [iirdf_pkg::COEF_DEPTH];
  logic signed [31:0] den_coef [iirdf_pkg::COEF_DEPTH];
  logic signed [47:0] delay_line [iirdf_pkg::HIST_DEPTH];
  int unsigned taps_in_use = 1;
  bit share_set0 = 1'b1;

  // generator bookkeeping: which coefficients have been written
  bit num_known [iirdf_pkg::COEF_DEPTH];
  bit den_known [iirdf_pkg::COEF_DEPTH];
  int unsigned gen_taps = 1;
  bit gen_shared = 1'b1;

  iirdf_pkg::req_t pending [$];
  iirdf_pkg::rsp_t expected_beats [$];
  int errors = 0;
  bit idle_on = 1'b1;
  int unsigned cyc = 0;
  int quiet_cnt = 0;
  int hold_left = 0;

  function automatic int unsigned clamp_taps(int unsigned t);
    if (t < 1) return 1;
    if (t > iirdf_pkg::MAX_TAPS) return iirdf_pkg::MAX_TAPS;
    return t;
  endfunction

  function automatic logic signed [47:0] clip_hist(logic signed [127:0] v, inout bit flag);
    if (v > HMAX) begin
      flag = 1'b1;
      return HMAX[47:0];
    end
    if (v < HMIN) begin
      flag = 1'b1;
      return HMIN[47:0];
    end
    return v[47:0];
  endfunction

  task automatic filter_apply(iirdf_pkg::req_t r);
    logic signed [127:0] x, y, yh, acc, t, b, a, z;
    logic signed [15:0] o;
    int unsigned n, cb, hb;
    bit flag;
    iirdf_pkg::rsp_t beat;
    flag = 1'b0;
    beat = '0;
    hb = r.slot * (iirdf_pkg::MAX_TAPS - 1);
    case (r.func)
      iirdf_pkg::FUNC_COEF_WR: begin
        if (r.coef_kind) den_coef[r.slot * iirdf_pkg::MAX_TAPS + r.tap] = r.word[31:0];
        else num_coef[r.slot * iirdf_pkg::MAX_TAPS + r.tap] = r.word[31:0];
      end
      iirdf_pkg::FUNC_HIST_WR: begin
        if (r.tap != iirdf_pkg::LAST_TAP) delay_line[hb + r.tap] = r.word;
      end
      iirdf_pkg::FUNC_HIST_RD: begin
        beat.result_kind = iirdf_pkg::RESULT_HIST;
        beat.history_word = (r.tap != iirdf_pkg::LAST_TAP) ? delay_line[hb + r.tap] : 48'sd0;
        expected_beats.push_back(beat);
      end
      default: begin
        n = clamp_taps(taps_in_use);
        cb = (share_set0 ? 0 : r.slot) * iirdf_pkg::MAX_TAPS;
        x = r.sample;
        b = num_coef[cb];
        y = b * x;
        if (n > 1) begin
          z = delay_line[hb];
          y = y + z;
        end
        t = (y + HALF) >>> 24;
        if (t > 128'sd32767) begin
          o = 16'sh7fff;
          flag = 1'b1;
        end else if (t < -128'sd32768) begin
          o = -16'sd32768;
          flag = 1'b1;
        end else o = t[15:0];
        if (n > 1) begin
          yh = clip_hist(y, flag);
          for (int j = 0; j + 1 < n; j++) begin
            b = num_coef[cb + j + 1];
            a = den_coef[cb + j + 1];
            acc = (b * x) <<< 24;
            if (j + 2 < n) begin
              z = delay_line[hb + j + 1];
              acc = acc + (z <<< 24);
            end
            acc = (acc - a * yh + HALF) >>> 24;
            delay_line[hb + j] = clip_hist(acc, flag);
          end
        end
        beat.result_kind = iirdf_pkg::RESULT_FILTER;
        beat.out_sample = o;
        beat.saturated = flag;
        expected_beats.push_back(beat);
      end
    endcase
  endtask

  // stimulus building
  task automatic push_item(logic [1:0] f, logic [5:0] s, logic [2:0] tp, logic k,
                           logic [47:0] w, logic [15:0] smp);
    iirdf_pkg::req_t r;
    r.func = f;
    r.slot = s;
    r.tap = tp;
    r.coef_kind = k;
    r.word = w;
    r.sample = smp;
    pending.push_back(r);
    if (f == iirdf_pkg::FUNC_COEF_WR) begin
      if (k) den_known[s * iirdf_pkg::MAX_TAPS + tp] = 1'b1;
      else num_known[s * iirdf_pkg::MAX_TAPS + tp] = 1'b1;
    end
  endtask

  function automatic logic [31:0] rand_coef();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    if (p < 90) return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    return $urandom;
  endfunction

  function automatic logic [47:0] rand_hist();
    logic [47:0] w;
    w = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) w = 48'($signed(w[40:0]));
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h7fff;
    if (p == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic add_filter(logic [5:0] s, logic [15:0] smp);
    int unsigned n, set;
    n = clamp_taps(gen_taps);
    set = gen_shared ? 0 : s;
    for (int t = 0; t < n; t++) begin
      if (!num_known[set * iirdf_pkg::MAX_TAPS + t])
        push_item(iirdf_pkg::FUNC_COEF_WR, 6'(set), 3'(t), 1'b0,
                  {16'($urandom), rand_coef()}, 16'($urandom));
      if (t > 0 && !den_known[set * iirdf_pkg::MAX_TAPS + t])
        push_item(iirdf_pkg::FUNC_COEF_WR, 6'(set), 3'(t), 1'b1,
                  {16'($urandom), rand_coef()}, 16'($urandom));
    end
    push_item(iirdf_pkg::FUNC_FILTER, s, 3'($urandom), 1'($urandom),
              48'({$urandom, $urandom}), smp);
  endtask

  task automatic add_random(int cnt);
    int unsigned p;
    logic [5:0] s;
    for (int i = 0; i < cnt; i++) begin
      p = $urandom_range(0, 99);
      s = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
      if (p < 55) add_filter(s, rand_sample());
      else if (p < 70) begin
        // zero coefficient now and then, numerator or denominator
        push_item(iirdf_pkg::FUNC_COEF_WR, s, 3'($urandom), 1'($urandom),
                  {16'($urandom), ($urandom_range(0, 4) == 0) ? 32'd0 : rand_coef()},
                  16'($urandom));
      end
      else if (p < 85) push_item(iirdf_pkg::FUNC_HIST_WR, s, 3'($urandom), 1'($urandom),
                                 rand_hist(), 16'($urandom));
      else push_item(iirdf_pkg::FUNC_HIST_RD, s, 3'($urandom), 1'($urandom),
                     48'({$urandom, $urandom}), 16'($urandom));
    end
  endtask

  task automatic add_directed();
    push_item(iirdf_pkg::FUNC_COEF_WR, 0, 0, 1'b0, 48'hffff_0100_0000, 16'h0);
    add_filter(0, 16'h7fff);
    add_filter(63, 16'h8000);
    add_filter(5, 16'h0000);
    // half-up rounding at gain one half
    push_item(iirdf_pkg::FUNC_COEF_WR, 0, 0, 1'b0, 48'h0000_0080_0000, 16'h0);
    add_filter(1, 16'h0001);
    add_filter(1, 16'hffff);
    push_item(iirdf_pkg::FUNC_COEF_WR, 0, 0, 1'b0, 48'h5a5a_7fff_ffff, 16'hffff);
    add_filter(2, 16'h7fff);
    add_filter(2, 16'h8000);
    push_item(iirdf_pkg::FUNC_COEF_WR, 0, 0, 1'b0, 48'h0000_8000_0000, 16'h0);
    add_filter(3, 16'h7fff);
    add_filter(3, 16'h8000);
    push_item(iirdf_pkg::FUNC_COEF_WR, 63, iirdf_pkg::LAST_TAP, 1'b1, 48'hffff_ffff_ffff, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_WR, 0, 0, 1'b0, 48'h7fff_ffff_ffff, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_WR, 63, 6, 1'b1, 48'h8000_0000_0000, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_WR, 9, iirdf_pkg::LAST_TAP, 1'b0, 48'h1234_5678_9abc, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_RD, 0, 0, 1'b0, 48'h0, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_RD, 63, 6, 1'b0, 48'h0, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_RD, 9, iirdf_pkg::LAST_TAP, 1'b0, 48'h0, 16'h0);
    push_item(iirdf_pkg::FUNC_HIST_RD, 10, 3, 1'b1, 48'hffff_ffff_ffff, 16'hffff);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == iirdf_pkg::CFG_TAP_COUNT) begin
      taps_in_use = val;
      gen_taps = val;
    end else begin
      share_set0 = val[0];
      gen_shared = val[0];
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || req_valid || expected_beats.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned tap_plan [11] = '{8, 2, 0, 8, 15, 4, 5, 3, 7, 1, 6};
    bit share_plan [11] = '{1, 0, 1, 0, 0, 1, 0, 1, 0, 0, 1};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(100);
    drain();
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(iirdf_pkg::CFG_TAP_COUNT, 4'(tap_plan[ph]));
      write_reg(iirdf_pkg::CFG_SHARED, 4'(share_plan[ph]));
      idle_on = (ph != 3);
      add_random(90);
      drain();
    end
    if (errors == 0) $display("multichannel_iir_df2t_filter_unit: match");
    else $display("multichannel_iir_df2t_filter_unit: mismatch");
    $finish;
  end

  // request driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) filter_apply(req);
      if (!req_valid || !req_stall) begin
        if (pending.size() != 0 && !(idle_on && $urandom_range(0, 99) < 16)) begin
          req <= pending.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with random and long back-pressure
  always @(posedge clk) begin
    iirdf_pkg::rsp_t want;
    cyc <= cyc + 1;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: got %p", $time, rsp);
      end else begin
        want = expected_beats.pop_front();
        if (rsp.result_kind !== want.result_kind || rsp.out_sample !== want.out_sample ||
            rsp.history_word !== want.history_word || rsp.saturated !== want.saturated) begin
          errors++;
          $display("%0t beat mismatch: expected %p got %p", $time, want, rsp);
        end
      end
    end
    if (cyc % 9000 == 2000) hold_left <= 300;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 16);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("multichannel_iir_df2t_filter_unit: mismatch");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

endmodule
